### hdl/assert_macros.svh
// Assertion macros shared by the RTL; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### hdl/dcse_pkg.sv
// Shared types and constants for the DCT coefficient message extractor.
`default_nettype none
package dcse_pkg;

    localparam int COEF_W = 16;
    localparam int POS_W  = 6;
    localparam int MAG_W  = COEF_W + 1;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int WGT_W  = 4;
    localparam int ACC_W  = 6;

    localparam logic [MAG_W-1:0] HEADER_MIN_MAG = MAG_W'(15);
    localparam logic [MAG_W-1:0] DATA_MIN_MAG   = MAG_W'(4);

    // One result of one step of the extractor
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } step_res_t;

endpackage
`default_nettype wire

### hdl/dcse_coef_if.sv
// Valid/ready channel carrying one coefficient with its block position.
`default_nettype none
interface dcse_coef_if
    import dcse_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COEF_W-1:0] coefficient;
    logic [POS_W-1:0]  position;
    logic              start_of_image;

    modport source (output valid, output coefficient, output position,
                    output start_of_image, input ready);
    modport sink   (input valid, input coefficient, input position,
                    input start_of_image, output ready);
endinterface
`default_nettype wire

### hdl/dcse_byte_if.sv
// Valid/ready channel carrying one extracted message byte.
`default_nettype none
interface dcse_byte_if
    import dcse_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] message_byte;
    logic              last_byte;

    modport source (output valid, output message_byte, output last_byte, input ready);
    modport sink   (input valid, input message_byte, input last_byte, output ready);
endinterface
`default_nettype wire

### hdl/dcse_step.sv
// Header/data state machine: decodes one registered coefficient per step.
`default_nettype none
module dcse_step
    import dcse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [COEF_W-1:0] coefficient,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic              start_of_image,
    output step_res_t              res
);

    typedef enum logic [2:0] {
        PH_COUNT   = 3'd0,
        PH_WEIGHTS = 3'd1,
        PH_START   = 3'd2,
        PH_DATA    = 3'd3,
        PH_DONE    = 3'd4,
        PH_STUCK   = 3'd5
    } phase_t;

    phase_t           phase_reg, phase_next, phase_cur;
    logic [WGT_W-1:0] weight_reg, weight_next, weight_cur;
    logic [LEN_W-1:0] length_reg, length_next, length_cur;
    logic [LEN_W-1:0] emitted_reg, emitted_next, emitted_cur;
    logic [1:0]       pairs_reg, pairs_next, pairs_cur;
    logic [ACC_W-1:0] acc_reg, acc_next, acc_cur;
    logic [MAG_W-1:0] mag;
    logic [LEN_W-1:0] emitted_inc;
    logic             header_hit;

    // two's complement magnitude; -32768 gives 32768
    assign mag = coefficient[COEF_W-1]
               ? MAG_W'(0) - {coefficient[COEF_W-1], coefficient}
               : {1'b0, coefficient};
    assign header_hit  = mag > HEADER_MIN_MAG;
    assign emitted_inc = emitted_cur + LEN_W'(1);

    always_comb
    begin
        // start of image clears state before this coefficient is handled
        phase_cur   = start_of_image ? PH_COUNT : phase_reg;
        weight_cur  = start_of_image ? '0 : weight_reg;
        length_cur  = start_of_image ? '0 : length_reg;
        emitted_cur = start_of_image ? '0 : emitted_reg;
        pairs_cur   = start_of_image ? '0 : pairs_reg;
        acc_cur     = start_of_image ? '0 : acc_reg;

        phase_next   = phase_cur;
        weight_next  = weight_cur;
        length_next  = length_cur;
        emitted_next = emitted_cur;
        pairs_next   = pairs_cur;
        acc_next     = acc_cur;
        res          = '0;

        if (position != '0)
        begin
            unique case (phase_cur)
                PH_COUNT:
                begin
                    if (header_hit)
                    begin
                        weight_next = mag[WGT_W-1:0];
                        length_next = '0;
                        phase_next  = (mag[WGT_W-1:0] == '0) ? PH_STUCK : PH_WEIGHTS;
                    end
                end
                PH_WEIGHTS:
                begin
                    if (header_hit)
                    begin
                        if (mag[0])
                            length_next = length_cur + (LEN_W'(1) << weight_cur);
                        weight_next = weight_cur - WGT_W'(1);
                        if (weight_cur == WGT_W'(1))
                            phase_next = PH_START;
                    end
                end
                PH_START:
                begin
                    if (header_hit)
                    begin
                        phase_next   = PH_DATA;
                        emitted_next = '0;
                        pairs_next   = '0;
                        acc_next     = '0;
                    end
                end
                PH_DATA:
                begin
                    if (mag >= DATA_MIN_MAG)
                    begin
                        if (pairs_cur != 2'd3)
                        begin
                            acc_next   = {acc_cur[ACC_W-3:0], mag[1:0]};
                            pairs_next = pairs_cur + 2'd1;
                        end
                        else
                        begin
                            res.valid  = 1'b1;
                            res.data   = {acc_cur, mag[1:0]};
                            pairs_next = '0;
                            acc_next   = '0;
                            // zero byte count: stream forever, never mark last
                            if (length_cur != '0)
                            begin
                                emitted_next = emitted_inc;
                                if (emitted_inc == length_cur)
                                begin
                                    res.last   = 1'b1;
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    // done, stuck header and unused codes ignore input
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_COUNT;
            weight_reg  <= '0;
            length_reg  <= '0;
            emitted_reg <= '0;
            pairs_reg   <= '0;
            acc_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            weight_reg  <= weight_next;
            length_reg  <= length_next;
            emitted_reg <= emitted_next;
            pairs_reg   <= pairs_next;
            acc_reg     <= acc_next;
        end
    end

endmodule
`default_nettype wire

### hdl/dct_coefficient_stego_extractor.sv
// Path: a coefficient passes the input register, then the result register, before its byte is valid.
// Throughput: one coefficient per cycle; the single-pass decode between the two registers
// sets it, and a held result only stalls the input once both registers are full.
// Reset: rst_n asynchronously clears the phase, header and byte counters and both valids.
// start_of_image on a coefficient clears the phase, header and byte counters before that coefficient is decoded.
`default_nettype none
`include "assert_macros.svh"
module dct_coefficient_stego_extractor
    import dcse_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dcse_coef_if.sink   coef,
    dcse_byte_if.source msg
);

    logic              in_valid_reg;
    logic [COEF_W-1:0] coef_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              sof_reg;
    logic              res_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              advance;
    logic              step;
    step_res_t         step_res;

    assign advance    = !res_valid_reg || msg.ready;
    assign step       = in_valid_reg && advance;
    assign coef.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (coef.ready)
            in_valid_reg <= coef.valid;
    end

    always_ff @(posedge clk)
    begin
        if (coef.valid && coef.ready)
        begin
            coef_reg <= coef.coefficient;
            pos_reg  <= coef.position;
            sof_reg  <= coef.start_of_image;
        end
    end

    dcse_step u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .coefficient    (coef_reg),
        .position       (pos_reg),
        .start_of_image (sof_reg),
        .res            (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= step && step_res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && step_res.valid)
        begin
            byte_reg <= step_res.data;
            last_reg <= step_res.last;
        end
    end

    assign msg.valid        = res_valid_reg;
    assign msg.message_byte = byte_reg;
    assign msg.last_byte    = last_reg;

    `ASSERT_CLK(a_empty_result_takes_input, clk, rst_n, !res_valid_reg |-> coef.ready, "input stalled with empty result register")
    `ASSERT_CLK(a_held_result_blocks_step, clk, rst_n, (res_valid_reg && !msg.ready) |-> !step, "step taken while result waits")
    `ASSERT_NEVER(a_last_implies_valid, clk, rst_n, step_res.last && !step_res.valid, "last flag without a byte")
    `ASSERT_CLK(a_no_byte_after_last, clk, rst_n, (step && step_res.valid && step_res.last) |=> !(step && step_res.valid && !sof_reg), "byte after last without start of image")

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for dct_coefficient_stego_extractor: predicted message bytes vs. DUT.
`timescale 1ns / 1ps

module tb
    import dcse_pkg::*;
();

    localparam int TARGET_ITEMS  = 1550;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;

    typedef enum logic [2:0] {
        WAIT_COUNT  = 3'd0,
        GET_WEIGHTS = 3'd1,
        WAIT_START  = 3'd2,
        IN_DATA     = 3'd3,
        MSG_DONE    = 3'd4,
        HDR_STUCK   = 3'd5
    } ext_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } msg_byte_t;

    // Tracks the extractor state and holds the message bytes still owed by the DUT.
    class message_predictor;
        ext_phase_t        phase;
        logic [WGT_W-1:0]  weight;
        logic [LEN_W-1:0]  msg_len;
        logic [LEN_W-1:0]  sent;
        logic [1:0]        pairs;
        logic [ACC_W-1:0]  acc;
        msg_byte_t         pending[$];
        int                errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase   = WAIT_COUNT;
            weight  = '0;
            msg_len = '0;
            sent    = '0;
            pairs   = '0;
            acc     = '0;
        endfunction

        function void take_coefficient(logic [COEF_W-1:0] c, logic [POS_W-1:0] p, logic soi);
            logic signed [MAG_W-1:0] sval;
            logic [MAG_W-1:0]        mag;
            msg_byte_t               e;
            if (soi)
                clear();
            if (p == 0)
                return;
            sval = {c[COEF_W-1], c};
            mag  = sval[MAG_W-1] ? MAG_W'(-sval) : MAG_W'(sval);
            case (phase)
                WAIT_COUNT:
                    if (mag > HEADER_MIN_MAG)
                    begin
                        weight  = mag[WGT_W-1:0];
                        msg_len = '0;
                        phase   = (weight == 0) ? HDR_STUCK : GET_WEIGHTS;
                    end
                GET_WEIGHTS:
                    if (mag > HEADER_MIN_MAG)
                    begin
                        if (mag[0])
                            msg_len = msg_len + (LEN_W'(1) << weight);
                        weight = weight - 1'b1;
                        if (weight == 0)
                            phase = WAIT_START;
                    end
                WAIT_START:
                    if (mag > HEADER_MIN_MAG)
                    begin
                        phase = IN_DATA;
                        sent  = '0;
                        pairs = '0;
                        acc   = '0;
                    end
                IN_DATA:
                    if (mag >= DATA_MIN_MAG)
                    begin
                        if (pairs < 2'd3)
                        begin
                            acc   = {acc[ACC_W-3:0], mag[1:0]};
                            pairs = pairs + 1'b1;
                        end
                        else
                        begin
                            e.data = {acc, mag[1:0]};
                            e.last = 1'b0;
                            pairs  = '0;
                            acc    = '0;
                            // zero byte count streams forever without a last marker
                            if (msg_len != 0)
                            begin
                                sent = sent + 1'b1;
                                if (sent == msg_len)
                                begin
                                    e.last = 1'b1;
                                    phase  = MSG_DONE;
                                end
                            end
                            pending.push_back(e);
                        end
                    end
                default: ;
            endcase
        endfunction

        function void check_byte(logic [BYTE_W-1:0] b, logic l);
            msg_byte_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected message byte %02h last %0b", b, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (b !== e.data)
            begin
                $error("message_byte: expected %02h, got %02h", e.data, b);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("last_byte: expected %0b, got %0b", e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dcse_coef_if coef_ch ();
    dcse_byte_if byte_ch ();

    dct_coefficient_stego_extractor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef_ch),
        .msg   (byte_ch)
    );

    message_predictor pred = new();

    int burst_left   = 0;
    int useful_items = 0;
    bit gapless      = 1'b0;
    bit hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- coefficient generation ----------------

    function automatic logic [COEF_W-1:0] signed_coef(int unsigned mag);
        if (mag >= 32768)
            return 16'h8000;
        return ($urandom_range(0, 1) == 1) ? COEF_W'(-int'(mag)) : COEF_W'(mag);
    endfunction

    function automatic logic [POS_W-1:0] ac_pos();
        return POS_W'($urandom_range(1, 63));
    endfunction

    function automatic int unsigned header_mag(bit odd);
        if (!odd && $urandom_range(0, 19) == 0)
            return 32768;
        return ($urandom_range(8, 16383) << 1) | odd;
    endfunction

    function automatic int unsigned data_mag();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32768;
        if (r < 7)
            return $urandom_range(4, 63);
        return $urandom_range(4, 32767);
    endfunction

    // ---------------- coefficient channel ----------------

    task automatic send_item(input logic [COEF_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic soi);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                coef_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        coef_ch.valid          <= 1'b1;
        coef_ch.coefficient    <= c;
        coef_ch.position       <= p;
        coef_ch.start_of_image <= soi;
        @(posedge clk);
        while (!coef_ch.ready)
            @(posedge clk);
        pred.take_coefficient(c, p, soi);
        if (p != 0)
            useful_items++;
    endtask

    task automatic wait_drained();
        coef_ch.valid <= 1'b0;
        while (pred.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_noise(bit in_data);
        if ($urandom_range(0, 3) == 0)
            send_item(COEF_W'($urandom_range(0, 65535)), '0, 1'b0);
        else
            send_item(signed_coef($urandom_range(0, in_data ? 3 : 15)), ac_pos(), 1'b0);
    endtask

    // One image: random header (may be cut short), then data; or random items only.
    task automatic run_frame();
        int unsigned w;
        int          n;
        bit          zero_len;
        bit          odd;
        if ($urandom_range(0, 99) < 12)
        begin
            n = $urandom_range(5, 30);
            repeat (n)
                send_item(COEF_W'($urandom_range(0, 65535)), POS_W'($urandom_range(0, 63)),
                          $urandom_range(0, 15) == 0);
            return;
        end
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
        zero_len = ($urandom_range(0, 6) == 0);
        send_item(signed_coef(($urandom_range(1, 2047) << 4) | w), ac_pos(),
                  $urandom_range(0, 19) != 0);
        for (int k = w; k >= 1; k--)
        begin
            if ($urandom_range(0, 4) == 0)
                send_noise(1'b0);
            // truncated header now and then
            if ($urandom_range(0, 49) == 0)
                return;
            odd = !zero_len && ((k <= 3) ? ($urandom_range(0, 1) == 1)
                                         : ($urandom_range(0, 11) == 0));
            send_item(signed_coef(header_mag(odd)), ac_pos(), 1'b0);
        end
        send_item(signed_coef(header_mag(1'($urandom_range(0, 1)))), ac_pos(), 1'b0);
        n = $urandom_range(8, 100);
        repeat (n)
        begin
            if ($urandom_range(0, 6) == 0)
                send_noise(1'b1);
            else
                send_item(signed_coef(data_mag()), ac_pos(), 1'b0);
        end
        if ($urandom_range(0, 29) == 0)
            wait_drained();
    endtask

    // ---------------- byte channel ----------------

    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int cyc;
        bit held;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        cyc       = 0;
        held      = 1'b0;
        byte_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rst_n && byte_ch.valid && byte_ch.ready)
                pred.check_byte(byte_ch.message_byte, byte_ch.last_byte);
            if (hold_request && !held)
            begin
                hold_left = HOLD_CYCLES;
                held      = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 400);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                byte_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: byte_ch.ready <= 1'b1;
                    1: byte_ch.ready <= 1'($urandom_range(0, 1));
                    2: byte_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: byte_ch.ready <= (cyc % 7) < 3;
                endcase
            end
        end
    end

    // ---------------- watchdog ----------------

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((coef_ch.valid && coef_ch.ready) || (byte_ch.valid && byte_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial
    begin
        rst_n                  <= 1'b0;
        coef_ch.valid          <= 1'b0;
        coef_ch.coefficient    <= '0;
        coef_ch.position       <= '0;
        coef_ch.start_of_image <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero weight count locks the header until the next image
        send_item(16'h8000, 6'd0, 1'b1);
        send_item(COEF_W'(16), 6'd63, 1'b0);
        send_item(16'h7FFF, 6'd1, 1'b0);
        // two-byte message, boundary magnitudes
        send_item(COEF_W'(-15), 6'd3, 1'b1);
        send_item(COEF_W'(17), 6'd4, 1'b0);
        send_item(COEF_W'(-19), 6'd5, 1'b0);
        send_item(16'h8000, 6'd7, 1'b0);
        send_item(COEF_W'(3), 6'd8, 1'b0);
        send_item(16'h8000, 6'd9, 1'b0);
        send_item(16'h7FFF, 6'd10, 1'b0);
        send_item(COEF_W'(-5), 6'd11, 1'b0);
        send_item(COEF_W'(4), 6'd12, 1'b0);
        send_item(COEF_W'(-6), 6'd21, 1'b0);
        send_item(COEF_W'(7), 6'd42, 1'b0);
        send_item(16'h7FFF, 6'd0, 1'b0);
        send_item(COEF_W'(-32767), 6'd62, 1'b0);
        send_item(COEF_W'(9), 6'd33, 1'b0);
        // after the last byte everything is dropped
        send_item(COEF_W'(100), 6'd20, 1'b0);
        // zero byte count: a byte without a last marker
        send_item(COEF_W'(-18), 6'd1, 1'b1);
        send_item(COEF_W'(16), 6'd2, 1'b0);
        send_item(COEF_W'(-20), 6'd3, 1'b0);
        send_item(COEF_W'(24), 6'd4, 1'b0);
        send_item(COEF_W'(255), 6'd48, 1'b0);
        send_item(COEF_W'(-254), 6'd16, 1'b0);
        send_item(COEF_W'(253), 6'd32, 1'b0);
        send_item(COEF_W'(-252), 6'd63, 1'b0);
        wait_drained();

        // back-pressure: receiver holds off while a zero-length stream keeps coming
        gapless      = 1'b1;
        hold_request = 1'b1;
        send_item(COEF_W'(17), ac_pos(), 1'b1);
        send_item(COEF_W'(16), ac_pos(), 1'b0);
        send_item(COEF_W'(-16), ac_pos(), 1'b0);
        repeat (80)
            send_item(signed_coef(data_mag()), ac_pos(), 1'b0);
        gapless = 1'b0;
        wait_drained();

        while (useful_items < TARGET_ITEMS)
            run_frame();

        wait_drained();
        repeat (20) @(posedge clk);
        if (pred.errors == 0 && pred.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
